/* rtl/core/rbst_pkg.sv */
// ----------------------------------------------------------------------------
// rbst_pkg: shared types and constants
// Types, widths and register indexes for the ray/box slab test core.
// ----------------------------------------------------------------------------
package rbst_pkg;

    localparam int NUM_AXES    = 3;
    localparam int DIR_W       = 16;              // Q1.15 direction
    localparam int DIV_W       = DIR_W + 1;       // divisor magnitude, holds 2^15
    localparam int RECIP_W     = 48;              // signed Q17.31 reciprocal
    localparam int RECIP_SHIFT = 46;              // reciprocal = 2^46 / dir
    localparam int RECIP_LO_W  = RECIP_W / 2;     // low partial-product slice
    localparam int CNT_W       = $clog2(RECIP_SHIFT + 1);
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z    = 3'd5;

    typedef logic signed [DIR_W-1:0]   t_dir;
    typedef logic signed [RECIP_W-1:0] t_recip;
    typedef t_dir   t_dir_vec   [NUM_AXES];
    typedef t_recip t_recip_vec [NUM_AXES];

endpackage

/* rtl/core/rbst_ifs.sv */
// ----------------------------------------------------------------------------
// rbst channel interfaces
// Cube request, hit result and register write channels, valid/ready each.
// ----------------------------------------------------------------------------
interface rbst_cube_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] cube_x;
    logic signed [COORD_BITS-1:0] cube_y;
    logic signed [COORD_BITS-1:0] cube_z;
    logic        [COORD_BITS-2:0] cube_edge;

    modport source (output valid, cube_x, cube_y, cube_z, cube_edge, input ready);
    modport sink   (input valid, cube_x, cube_y, cube_z, cube_edge, output ready);
endinterface

interface rbst_hit_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink   (input valid, hit, output ready);
endinterface

interface rbst_cfg_if #(
    parameter int DATA_BITS = 32
);
    logic                            valid;
    logic                            ready;
    logic [rbst_pkg::CFG_IDX_W-1:0]  index;
    logic [DATA_BITS-1:0]            data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/rbst_recip.sv */
// ----------------------------------------------------------------------------
// rbst_recip: direction reciprocal unit
// Restoring divider, one quotient bit per cycle, forms 2^46 / dir for the
// three axes in turn. A zero component divides as +1.
// ----------------------------------------------------------------------------
module rbst_recip (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  rbst_pkg::t_dir_vec    i_dir,
    output logic                  o_busy,
    output rbst_pkg::t_recip_vec  o_recip
);

    typedef enum logic {ST_IDLE, ST_RUN} t_state;

    t_state                             r_state;
    logic [1:0]                         r_axis;
    logic [rbst_pkg::CNT_W-1:0]         r_cnt;
    logic [rbst_pkg::DIR_W-1:0]         r_rem;
    logic [rbst_pkg::RECIP_SHIFT-1:0]   r_quo;
    rbst_pkg::t_recip_vec               r_recip;

    rbst_pkg::t_dir                     d_sel;
    logic                               d_neg;
    logic [rbst_pkg::DIV_W-1:0]         d_ext;
    logic [rbst_pkg::DIV_W-1:0]         d_mag;
    logic [rbst_pkg::DIV_W-1:0]         rem_sh;
    logic                               q_bit;
    logic [rbst_pkg::DIV_W-1:0]         n_rem;
    logic [rbst_pkg::RECIP_SHIFT:0]     n_quo;
    rbst_pkg::t_recip                   rcp_mag;
    rbst_pkg::t_recip                   n_recip;

    always_comb begin
        d_sel  = i_dir[r_axis];
        d_neg  = d_sel[rbst_pkg::DIR_W-1];
        d_ext  = {d_sel[rbst_pkg::DIR_W-1], d_sel};
        d_mag  = d_neg ? (rbst_pkg::DIV_W'(0) - d_ext) : d_ext;
        if (d_sel == '0) begin
            d_mag = rbst_pkg::DIV_W'(1);
        end
        // the dividend is a single one at the top bit
        rem_sh  = {r_rem, (r_cnt == rbst_pkg::CNT_W'(rbst_pkg::RECIP_SHIFT))};
        q_bit   = (rem_sh >= d_mag);
        n_rem   = q_bit ? (rem_sh - d_mag) : rem_sh;
        n_quo   = {r_quo, q_bit};
        rcp_mag = {1'b0, n_quo};
        n_recip = d_neg ? (rbst_pkg::RECIP_W'(0) - rcp_mag) : rcp_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_axis  <= 2'd0;
            r_cnt   <= rbst_pkg::CNT_W'(rbst_pkg::RECIP_SHIFT);
            r_rem   <= '0;
            r_quo   <= '0;
        end else if (i_start) begin
            r_state <= ST_RUN;
            r_axis  <= 2'd0;
            r_cnt   <= rbst_pkg::CNT_W'(rbst_pkg::RECIP_SHIFT);
            r_rem   <= '0;
            r_quo   <= '0;
        end else begin
            case (r_state)
                ST_RUN: begin
                    if (r_cnt == '0) begin
                        r_recip[r_axis] <= n_recip;
                        r_rem           <= '0;
                        r_quo           <= '0;
                        r_cnt           <= rbst_pkg::CNT_W'(rbst_pkg::RECIP_SHIFT);
                        if (r_axis == 2'(rbst_pkg::NUM_AXES - 1)) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_axis <= r_axis + 2'd1;
                        end
                    end else begin
                        r_rem <= n_rem[rbst_pkg::DIR_W-1:0];
                        r_quo <= n_quo[rbst_pkg::RECIP_SHIFT-1:0];
                        r_cnt <= r_cnt - rbst_pkg::CNT_W'(1);
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_busy  = (r_state == ST_RUN);
    assign o_recip = r_recip;

endmodule

/* rtl/core/ray_box_slab_test_core.sv */
// ----------------------------------------------------------------------------
// ray_box_slab_test_core: ray against axis-aligned cube slab test
// Tests a stream of integer-grid cubes against one ray held in registers.
// ----------------------------------------------------------------------------
// Channels: i_cfg writes the ray (origin x/y/z at indexes 0..2, signed with
// FRAC_BITS fraction bits; direction x/y/z at indexes 3..5, Q1.15). i_cube
// carries one cube request (minimal corner and edge length) per accept.
// o_hit returns one hit bit per request, in request order.
// Throughput: one request per cycle unless o_hit.ready is low or the divider
// is busy. The six register stages are slab operands, split partial products,
// product sum, two min/max levels and hit register. Reset and direction
// writes start the reciprocal divider, one quotient bit per cycle, and
// i_cube.ready is low until all three reciprocals are formed. Origin
// writes take effect at once; i_cfg.ready is always high. Registers must
// be written only while no request is in flight; the core does not check.
// Stall: when o_hit.ready is low the result holds in the output register
// and the stages behind it keep filling; i_cube.ready drops only once
// every stage holds a request.
// ----------------------------------------------------------------------------
module ray_box_slab_test_core #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rbst_cfg_if.sink   i_cfg,
    rbst_cube_if.sink  i_cube,
    rbst_hit_if.source o_hit
);

    localparam int ORG_W = COORD_BITS + FRAC_BITS;
    localparam int A_W   = ORG_W + 2;                       // corner minus origin
    localparam int LO_W  = rbst_pkg::RECIP_LO_W;
    localparam int HI_W  = rbst_pkg::RECIP_W - LO_W;
    localparam int PL_W  = A_W + LO_W + 1;
    localparam int PH_W  = A_W + HI_W;
    localparam int T_W   = A_W + rbst_pkg::RECIP_W;
    localparam int NSTG  = 6;
    localparam int K_ENTER = 0;
    localparam int K_LEAVE = 1;

    // ---------------- configuration ----------------
    logic signed [ORG_W-1:0] r_org [rbst_pkg::NUM_AXES];
    rbst_pkg::t_dir_vec      r_dir;
    logic                    cfg_acc;
    logic                    dir_wr;

    assign i_cfg.ready = 1'b1;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign dir_wr      = cfg_acc && ((i_cfg.index == rbst_pkg::CFG_DIR_X) ||
                                     (i_cfg.index == rbst_pkg::CFG_DIR_Y) ||
                                     (i_cfg.index == rbst_pkg::CFG_DIR_Z));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_dir[0] <= rbst_pkg::DIR_W'(32767);
            r_dir[1] <= '0;
            r_dir[2] <= '0;
        end else if (cfg_acc) begin
            case (i_cfg.index)
                rbst_pkg::CFG_ORIGIN_X: r_org[0] <= i_cfg.data;
                rbst_pkg::CFG_ORIGIN_Y: r_org[1] <= i_cfg.data;
                rbst_pkg::CFG_ORIGIN_Z: r_org[2] <= i_cfg.data;
                rbst_pkg::CFG_DIR_X:    r_dir[0] <= i_cfg.data[rbst_pkg::DIR_W-1:0];
                rbst_pkg::CFG_DIR_Y:    r_dir[1] <= i_cfg.data[rbst_pkg::DIR_W-1:0];
                rbst_pkg::CFG_DIR_Z:    r_dir[2] <= i_cfg.data[rbst_pkg::DIR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- reciprocals ----------------
    logic                 rc_busy;
    rbst_pkg::t_recip_vec rcp;

    rbst_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dir_wr),
        .i_dir   (r_dir),
        .o_busy  (rc_busy),
        .o_recip (rcp)
    );

    // ---------------- pipeline control ----------------
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] en;
    logic            in_acc;

    always_comb begin
        en[NSTG-1] = !r_v[NSTG-1] || o_hit.ready;
        for (int s = NSTG - 2; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    assign i_cube.ready = en[0] && !rc_busy;
    assign in_acc       = i_cube.valid && i_cube.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= in_acc;
            end
            for (int s = 1; s < NSTG; s++) begin
                if (en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    // ---------------- stage 1: slab operands ----------------
    logic signed [COORD_BITS-1:0] cube_c [rbst_pkg::NUM_AXES];
    logic signed [A_W-1:0]        c_lo, c_hi, a_lo, a_hi, org_ext, edge_ext;
    logic signed [A_W-1:0]        n1_a  [rbst_pkg::NUM_AXES][2];
    logic signed [A_W-1:0]        r1_a  [rbst_pkg::NUM_AXES][2];

    assign cube_c[0] = i_cube.cube_x;
    assign cube_c[1] = i_cube.cube_y;
    assign cube_c[2] = i_cube.cube_z;

    always_comb begin
        edge_ext = signed'({{(A_W-COORD_BITS+1){1'b0}}, i_cube.cube_edge});
        for (int ax = 0; ax < rbst_pkg::NUM_AXES; ax++) begin
            c_lo    = signed'({{(A_W-COORD_BITS){cube_c[ax][COORD_BITS-1]}}, cube_c[ax]});
            c_hi    = c_lo + edge_ext;
            org_ext = signed'({{(A_W-ORG_W){r_org[ax][ORG_W-1]}}, r_org[ax]});
            a_lo    = (c_lo <<< FRAC_BITS) - org_ext;
            a_hi    = (c_hi <<< FRAC_BITS) - org_ext;
            // a negative reciprocal swaps which face is entered first
            if (rcp[ax][rbst_pkg::RECIP_W-1]) begin
                n1_a[ax][K_ENTER] = a_hi;
                n1_a[ax][K_LEAVE] = a_lo;
            end else begin
                n1_a[ax][K_ENTER] = a_lo;
                n1_a[ax][K_LEAVE] = a_hi;
            end
        end
    end

    // ---------------- stage 2: split partial products ----------------
    logic signed [PL_W-1:0] r2_plo [rbst_pkg::NUM_AXES][2];
    logic signed [PH_W-1:0] r2_phi [rbst_pkg::NUM_AXES][2];

    // ---------------- stage 3: full distances ----------------
    logic signed [T_W-1:0]  r3_t   [rbst_pkg::NUM_AXES][2];

    // ---------------- stages 4..6 ----------------
    logic signed [T_W-1:0]  r4_tmin_xy, r4_tmax_xy, r4_ez, r4_lz;
    logic signed [T_W-1:0]  r5_tmin, r5_tmax;
    logic                   r_hit;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_a <= n1_a;
        end
        if (en[1]) begin
            for (int ax = 0; ax < rbst_pkg::NUM_AXES; ax++) begin
                for (int k = 0; k < 2; k++) begin
                    r2_plo[ax][k] <= r1_a[ax][k] * $signed({1'b0, rcp[ax][LO_W-1:0]});
                    r2_phi[ax][k] <= r1_a[ax][k] * $signed(rcp[ax][rbst_pkg::RECIP_W-1:LO_W]);
                end
            end
        end
        if (en[2]) begin
            for (int ax = 0; ax < rbst_pkg::NUM_AXES; ax++) begin
                for (int k = 0; k < 2; k++) begin
                    r3_t[ax][k] <= signed'({r2_phi[ax][k], {LO_W{1'b0}}}) +
                                   signed'({{(T_W-PL_W){r2_plo[ax][k][PL_W-1]}},
                                            r2_plo[ax][k]});
                end
            end
        end
        if (en[3]) begin
            r4_tmin_xy <= (r3_t[0][K_ENTER] >= r3_t[1][K_ENTER]) ?
                          r3_t[0][K_ENTER] : r3_t[1][K_ENTER];
            r4_tmax_xy <= (r3_t[0][K_LEAVE] <= r3_t[1][K_LEAVE]) ?
                          r3_t[0][K_LEAVE] : r3_t[1][K_LEAVE];
            r4_ez      <= r3_t[2][K_ENTER];
            r4_lz      <= r3_t[2][K_LEAVE];
        end
        if (en[4]) begin
            r5_tmin <= (r4_tmin_xy >= r4_ez) ? r4_tmin_xy : r4_ez;
            r5_tmax <= (r4_tmax_xy <= r4_lz) ? r4_tmax_xy : r4_lz;
        end
        if (en[5]) begin
            // behind the origin, or slabs do not overlap
            r_hit <= !r5_tmax[T_W-1] && !(r5_tmin > r5_tmax);
        end
    end

    assign o_hit.valid = r_v[NSTG-1];
    assign o_hit.hit   = r_hit;

    // ---------------- assertions ----------------
    a_no_req_while_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> !rc_busy)
        else $error("cube request accepted while reciprocals are being formed");

    a_dir_wr_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dir_wr |=> rc_busy)
        else $error("direction write did not restart the reciprocal divider");

    a_recip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !rc_busy |-> ((rcp[0] != '0) && (rcp[1] != '0) && (rcp[2] != '0)))
        else $error("reciprocal is zero after the divider finished");

    a_recip_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !rc_busy |-> ((rcp[0][rbst_pkg::RECIP_W-1] == r_dir[0][rbst_pkg::DIR_W-1]) &&
                      (rcp[1][rbst_pkg::RECIP_W-1] == r_dir[1][rbst_pkg::DIR_W-1]) &&
                      (rcp[2][rbst_pkg::RECIP_W-1] == r_dir[2][rbst_pkg::DIR_W-1])))
        else $error("reciprocal sign differs from direction sign");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: ray/box slab test core bench
// Streams integer-grid cubes at a ray held in registers, predicts each hit bit
// with an exact slab test and checks results in order under random idle/stall.
// ----------------------------------------------------------------------------
module tb;

    localparam int COORD_W          = 16;
    localparam int FRAC_W           = 16;
    localparam int ORIGIN_W         = COORD_W + FRAC_W;
    localparam int STALL_PCT        = 37;
    localparam int SETTLE_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int RANDOM_PER_PHASE = 105;
    localparam int NUM_PHASES       = 11;

    // indexes the core has no register behind
    localparam logic [rbst_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [rbst_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef logic signed [127:0] t_dist;

    class slab_scoreboard;
        longint origin [rbst_pkg::NUM_AXES];
        longint dir    [rbst_pkg::NUM_AXES];
        longint recip  [rbst_pkg::NUM_AXES];
        bit     recip_stale;
        bit     exp_hits [$];
        int     errors;

        function new();
            origin      = '{0, 0, 0};
            dir         = '{32767, 0, 0};
            recip       = '{0, 0, 0};
            recip_stale = 1'b1;
            errors      = 0;
        endfunction

        function void write_reg(logic [rbst_pkg::CFG_IDX_W-1:0] idx,
                                logic [ORIGIN_W-1:0] data);
            case (idx)
                rbst_pkg::CFG_ORIGIN_X, rbst_pkg::CFG_ORIGIN_Y,
                rbst_pkg::CFG_ORIGIN_Z: begin
                    origin[idx - rbst_pkg::CFG_ORIGIN_X] =
                        longint'(signed'(data[ORIGIN_W-1:0]));
                end
                rbst_pkg::CFG_DIR_X, rbst_pkg::CFG_DIR_Y, rbst_pkg::CFG_DIR_Z: begin
                    dir[idx - rbst_pkg::CFG_DIR_X] =
                        longint'(signed'(data[rbst_pkg::DIR_W-1:0]));
                end
                default: return;
            endcase
            recip_stale = 1'b1;
        endfunction

        // 2^46 / d toward zero, zero direction taken as +1 lsb
        function longint reciprocal(longint d);
            longint q;
            if (d == 0)
                d = 1;
            q = (longint'(1) <<< rbst_pkg::RECIP_SHIFT) / ((d < 0) ? -d : d);
            return (d < 0) ? -q : q;
        endfunction

        function t_dist distance(longint grid, int axis);
            t_dist offs;
            t_dist rcp;
            offs = grid * (longint'(1) <<< FRAC_W) - origin[axis];
            rcp  = recip[axis];
            return offs * rcp;
        endfunction

        function void note_request(logic signed [COORD_W-1:0] cx,
                                   logic signed [COORD_W-1:0] cy,
                                   logic signed [COORD_W-1:0] cz,
                                   logic [COORD_W-2:0] span);
            longint lo [rbst_pkg::NUM_AXES];
            longint ext;
            t_dist  t1, t2, enter, leave, tmin, tmax;
            if (recip_stale) begin
                for (int a = 0; a < rbst_pkg::NUM_AXES; a++)
                    recip[a] = reciprocal(dir[a]);
                recip_stale = 1'b0;
            end
            lo[0] = cx;
            lo[1] = cy;
            lo[2] = cz;
            ext   = longint'(span);
            for (int a = 0; a < rbst_pkg::NUM_AXES; a++) begin
                t1    = distance(lo[a], a);
                t2    = distance(lo[a] + ext, a);
                enter = (t1 <= t2) ? t1 : t2;
                leave = (t1 <= t2) ? t2 : t1;
                if (a == 0) begin
                    tmin = enter;
                    tmax = leave;
                end else begin
                    if (enter > tmin) tmin = enter;
                    if (leave < tmax) tmax = leave;
                end
            end
            exp_hits.push_back(!(tmax < 0 || tmin > tmax));
        endfunction

        function void check_result(logic got);
            bit want;
            if (exp_hits.size() == 0) begin
                $display("%0t: hit result %b with no request outstanding", $time, got);
                errors++;
                return;
            end
            want = exp_hits.pop_front();
            if (want !== got) begin
                $display("%0t: hit bit wrong, expected %b actual %b", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   steady;
    int   quiet_cycles;

    slab_scoreboard sb = new();

    rbst_cfg_if  #(.DATA_BITS(ORIGIN_W)) cfg_ch ();
    rbst_cube_if #(.COORD_BITS(COORD_W)) cube_ch ();
    rbst_hit_if                          hit_ch ();

    ray_box_slab_test_core #(
        .COORD_BITS(COORD_W),
        .FRAC_BITS (FRAC_W)
    ) uut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_cfg  (cfg_ch),
        .i_cube (cube_ch),
        .o_hit  (hit_ch)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit take_break();
        return !steady && ($urandom_range(0, 99) < STALL_PCT);
    endfunction

    // result side: check, then pick next cycle's ready
    always @(posedge clk) begin
        if (rst_n && hit_ch.valid && hit_ch.ready)
            sb.check_result(hit_ch.hit);
        hit_ch.ready <= !take_break();
    end

    always @(posedge clk) begin
        if (!rst_n || (cube_ch.valid && cube_ch.ready) || (hit_ch.valid && hit_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ray_box_slab_test_core: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_ray_reg(input logic [rbst_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [ORIGIN_W-1:0] data);
        while (take_break()) begin
            cfg_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // direction write with junk in the unused upper bits
    task automatic write_dir(input logic [rbst_pkg::CFG_IDX_W-1:0] idx, input longint d);
        logic [ORIGIN_W-1:0] junk;
        junk = $urandom();
        write_ray_reg(idx, {junk[ORIGIN_W-1:rbst_pkg::DIR_W], d[rbst_pkg::DIR_W-1:0]});
    endtask

    task automatic send_cube(input logic signed [COORD_W-1:0] cx,
                             input logic signed [COORD_W-1:0] cy,
                             input logic signed [COORD_W-1:0] cz,
                             input logic [COORD_W-2:0] span);
        while (take_break()) begin
            cube_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cube_ch.valid     <= 1'b1;
        cube_ch.cube_x    <= cx;
        cube_ch.cube_y    <= cy;
        cube_ch.cube_z    <= cz;
        cube_ch.cube_edge <= span;
        @(posedge clk);
        while (!cube_ch.ready) @(posedge clk);
        sb.note_request(cx, cy, cz, span);
    endtask

    // mostly cubes placed around a point on the ray, some behind it, some
    // nudged just off it, and some plain noise
    task automatic send_ray_cube();
        longint p [rbst_pkg::NUM_AXES];
        longint t;
        int     pick, span, jit, axis;
        logic [31:0] r0, r1;
        pick = $urandom_range(0, 99);
        span = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 40);
        if (pick < 15) begin
            r0 = $urandom();
            r1 = $urandom();
            send_cube(r0[15:0], r0[31:16], r1[15:0], r1[30:16]);
            return;
        end
        if (pick < 70 || pick >= 85)
            t = $urandom_range(0, 3000);
        else
            t = -longint'($urandom_range(1, 3000));
        for (int a = 0; a < rbst_pkg::NUM_AXES; a++) begin
            jit  = $urandom_range(0, span);
            p[a] = (sb.origin[a] >>> FRAC_W) + (t * sb.dir[a]) / 32768 - jit;
        end
        if (pick >= 85) begin
            axis = $urandom_range(0, rbst_pkg::NUM_AXES - 1);
            jit  = $urandom_range(1, 4);
            if ($urandom_range(0, 1))
                p[axis] = p[axis] + span + jit;
            else
                p[axis] = p[axis] - jit;
        end
        send_cube(COORD_W'(p[0]), COORD_W'(p[1]), COORD_W'(p[2]), (COORD_W-1)'(span));
    endtask

    task automatic set_ray_random();
        logic [ORIGIN_W-1:0] org;
        longint d;
        int     pick;
        for (int a = 0; a < rbst_pkg::NUM_AXES; a++) begin
            if ($urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 9) == 0)
                    org = $urandom();
                else
                    org = {16'($signed($urandom_range(0, 6000)) - 3000), 16'($urandom())};
                write_ray_reg(rbst_pkg::CFG_IDX_W'(rbst_pkg::CFG_ORIGIN_X + a), org);
            end
        end
        for (int a = 0; a < rbst_pkg::NUM_AXES; a++) begin
            if ($urandom_range(0, 9) < 7) begin
                pick = $urandom_range(0, 9);
                if (pick < 2)
                    d = 0;
                else if (pick == 2)
                    d = $urandom_range(0, 1) ? 1 : -1;
                else if (pick == 3)
                    d = $urandom_range(0, 1) ? 32767 : -32768;
                else
                    d = longint'($signed(16'($urandom())));
                write_dir(rbst_pkg::CFG_IDX_W'(rbst_pkg::CFG_DIR_X + a), d);
            end
        end
        if ($urandom_range(0, 3) == 0)
            write_ray_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom());
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        cube_ch.valid <= 1'b0;
        while (sb.exp_hits.size() != 0) @(posedge clk);
    endtask

    initial begin
        rst_n             <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= rbst_pkg::CFG_ORIGIN_X;
        cfg_ch.data       <= '0;
        cube_ch.valid     <= 1'b0;
        cube_ch.cube_x    <= '0;
        cube_ch.cube_y    <= '0;
        cube_ch.cube_z    <= '0;
        cube_ch.cube_edge <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset ray: origin zero, heading +x, y and z direction zero
        send_cube(0, 0, 0, 0);
        send_cube(5, -1, -1, 2);
        send_cube(-5, -1, -1, 2);
        send_cube(5, 1, 0, 1);
        send_cube(5, 0, 0, 1);
        send_cube(5, -1, -1, 1);
        send_cube(-1, -1, -1, 1);
        send_cube(-32768, -32768, -32768, 32767);
        send_cube(32767, 32767, 32767, 32767);
        send_cube(-1, -1, -1, 32767);
        send_cube(32767, -1, -1, 32767);
        send_cube(-32768, -32768, -32768, 0);
        send_cube(32767, 32767, -32768, 0);
        send_cube(0, -16384, -16384, 16384);
        send_cube(3, 0, -1, 0);
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            send_ray_cube();
        drain();

        for (int ph = 1; ph < NUM_PHASES; ph++) begin
            steady = (ph == 2);
            if (ph == 1) begin
                write_ray_reg(rbst_pkg::CFG_ORIGIN_X, 32'h7fff_ffff);
                write_ray_reg(rbst_pkg::CFG_ORIGIN_Y, 32'h8000_0000);
                write_ray_reg(rbst_pkg::CFG_ORIGIN_Z, 32'h0000_0000);
                write_dir(rbst_pkg::CFG_DIR_X, -32768);
                write_dir(rbst_pkg::CFG_DIR_Y, 32767);
                write_dir(rbst_pkg::CFG_DIR_Z, 0);
                write_ray_reg(CFG_SPARE_LO, $urandom());
                write_ray_reg(CFG_SPARE_HI, $urandom());
                cfg_ch.valid <= 1'b0;
                send_cube(-32768, 32767, 0, 32767);
                send_cube(32767, -32768, -1, 1);
                send_cube(-32768, -32768, 0, 0);
            end else if (ph == 2) begin
                write_ray_reg(rbst_pkg::CFG_ORIGIN_X, 32'h8000_0000);
                write_ray_reg(rbst_pkg::CFG_ORIGIN_Y, 32'h7fff_ffff);
                write_ray_reg(rbst_pkg::CFG_ORIGIN_Z, 32'h0001_8000);
                write_dir(rbst_pkg::CFG_DIR_X, -32768);
                write_dir(rbst_pkg::CFG_DIR_Y, -32768);
                write_dir(rbst_pkg::CFG_DIR_Z, -32768);
                cfg_ch.valid <= 1'b0;
            end else begin
                set_ray_random();
            end
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                send_ray_cube();
            drain();
        end

        steady = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.exp_hits.size() == 0)
            $display("ray_box_slab_test_core: match");
        else
            $display("ray_box_slab_test_core: mismatch");
        $finish;
    end

endmodule
